@@ hdl/binary_gps_frame_receiver_defines.svh @@
// assertion macros for the binary gps frame receiver
`ifndef BINARY_GPS_FRAME_RECEIVER_DEFINES_SVH
`define BINARY_GPS_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BGFR_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define BGFR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hdl/bgfr_pkg.sv @@
// shared types and constants for the binary gps frame receiver
package bgfr_pkg;

   localparam int LEN_W   = 15;
   localparam int SUM_W   = 15;
   localparam int CKS_W   = 16;
   localparam int BYTE_W  = 8;
   localparam int STAT_W  = 2;
   localparam int TDATA_W = 72;

   localparam logic [BYTE_W-1:0] HDR1_BYTE = 8'hA0;
   localparam logic [BYTE_W-1:0] HDR2_BYTE = 8'hA2;
   localparam logic [BYTE_W-1:0] TR1_BYTE  = 8'hB0;
   localparam logic [BYTE_W-1:0] TR2_BYTE  = 8'hB3;
   localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 15'd255;

   localparam logic [STAT_W-1:0] ST_GOOD        = 2'd0;
   localparam logic [STAT_W-1:0] ST_CKS_BAD     = 2'd1;
   localparam logic [STAT_W-1:0] ST_TOO_LONG    = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD_TRAILER = 2'd3;

   // bit positions inside rsp_tdata
   localparam int DATA_LSB  = 0;
   localparam int IDX_LSB   = DATA_LSB + BYTE_W;
   localparam int FLEN_LSB  = IDX_LSB + LEN_W;
   localparam int STAT_LSB  = FLEN_LSB + LEN_W;
   localparam int RCKS_LSB  = STAT_LSB + STAT_W;
   localparam int CCKS_LSB  = RCKS_LSB + CKS_W;
   localparam int PAD_LSB   = CCKS_LSB + SUM_W;

   typedef enum logic [8:0] {
      PH_HDR1 = 9'b000000001,
      PH_HDR2 = 9'b000000010,
      PH_LEN1 = 9'b000000100,
      PH_LEN2 = 9'b000001000,
      PH_DATA = 9'b000010000,
      PH_CK1  = 9'b000100000,
      PH_CK2  = 9'b001000000,
      PH_TR1  = 9'b010000000,
      PH_TR2  = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic              frame_end;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  byte_index;
      logic [LEN_W-1:0]  frame_len;
      logic [STAT_W-1:0] status;
      logic [CKS_W-1:0]  recv_checksum;
      logic [SUM_W-1:0]  calc_checksum;
   } result_type;

endpackage

@@ hdl/bgfr_in_reg.sv @@
// input register stage for received bytes
module bgfr_in_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [bgfr_pkg::BYTE_W-1:0] req_tdata,
   input  logic                      advance,
   output logic                      held_valid,
   output logic [bgfr_pkg::BYTE_W-1:0] held_byte
);
   import bgfr_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         byte_ff <= req_tdata;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;
endmodule

@@ hdl/bgfr_deframer.sv @@
// frame state machine, payload sum and status decision
module bgfr_deframer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [bgfr_pkg::LEN_W-1:0]   csr_wr_data,
   input  logic                         advance,
   input  logic [bgfr_pkg::BYTE_W-1:0]  rx_byte,
   output logic                         res_valid,
   output bgfr_pkg::result_type         res
);
   import bgfr_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] max_len_ff;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CKS_W-1:0] recv_ff, recv_in;
   logic             over_ff, over_in;
   logic             ok_ff, ok_in;
   logic [LEN_W-1:0] len_new;
   logic [LEN_W-1:0] idx_next;
   logic [CKS_W-1:0] recv_new;

   assign len_new  = {len_ff[LEN_W-1:BYTE_W], rx_byte};
   assign idx_next = idx_ff + 15'd1;
   assign recv_new = {recv_ff[CKS_W-1:BYTE_W], rx_byte};

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      recv_in   = recv_ff;
      over_in   = over_ff;
      ok_in     = ok_ff;
      res_valid = 1'b0;
      res       = '0;
      res.frame_len = len_ff;
      unique case (phase_ff)
         PH_HDR1: begin
            if (rx_byte == HDR1_BYTE) begin
               phase_in = PH_HDR2;
            end
         end
         PH_HDR2: begin
            phase_in = (rx_byte == HDR2_BYTE) ? PH_LEN1 : PH_HDR1;
         end
         PH_LEN1: begin
            len_in   = {rx_byte[6:0], 8'd0};
            phase_in = PH_LEN2;
         end
         PH_LEN2: begin
            len_in   = len_new;
            idx_in   = '0;
            sum_in   = '0;
            over_in  = (len_new > max_len_ff);
            phase_in = (len_new == '0) ? PH_CK1 : PH_DATA;
         end
         PH_DATA: begin
            if (!over_ff) begin
               res_valid      = 1'b1;
               res.data_byte  = rx_byte;
               res.byte_index = idx_ff;
               sum_in         = sum_ff + {7'd0, rx_byte};
            end
            idx_in = idx_next;
            if (idx_next == len_ff) begin
               phase_in = PH_CK1;
            end
         end
         PH_CK1: begin
            recv_in  = {rx_byte, 8'd0};
            phase_in = PH_CK2;
         end
         PH_CK2: begin
            recv_in  = recv_new;
            ok_in    = (recv_new == {1'b0, sum_ff});
            phase_in = PH_TR1;
         end
         PH_TR1: begin
            if (rx_byte == TR1_BYTE) begin
               phase_in = PH_TR2;
            end else begin
               res_valid         = 1'b1;
               res.frame_end     = 1'b1;
               res.status        = ST_BAD_TRAILER;
               res.recv_checksum = recv_ff;
               res.calc_checksum = sum_ff;
               phase_in          = PH_HDR1;
            end
         end
         PH_TR2: begin
            res_valid         = 1'b1;
            res.frame_end     = 1'b1;
            res.recv_checksum = recv_ff;
            res.calc_checksum = sum_ff;
            if (rx_byte != TR2_BYTE) begin
               res.status = ST_BAD_TRAILER;
            end else if (over_ff) begin
               res.status = ST_TOO_LONG;
            end else begin
               res.status = ok_ff ? ST_GOOD : ST_CKS_BAD;
            end
            phase_in = PH_HDR1;
         end
         default: begin
            phase_in = PH_HDR1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR1;
         max_len_ff <= MAX_LEN_RESET;
         len_ff     <= '0;
         idx_ff     <= '0;
         sum_ff     <= '0;
         recv_ff    <= '0;
         over_ff    <= 1'b0;
         ok_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (advance) begin
            phase_ff <= phase_in;
            len_ff   <= len_in;
            idx_ff   <= idx_in;
            sum_ff   <= sum_in;
            recv_ff  <= recv_in;
            over_ff  <= over_in;
            ok_ff    <= ok_in;
         end
      end
   end
endmodule

@@ hdl/bgfr_out_reg.sv @@
// result register and packing onto the output stream
module bgfr_out_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  bgfr_pkg::result_type          res,
   output logic                          free,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bgfr_pkg::TDATA_W-1:0]  rsp_tdata,
   output logic                          rsp_tuser
);
   import bgfr_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = free ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.frame_end;
   assign rsp_tdata  = {1'b0, res_ff.calc_checksum, res_ff.recv_checksum, res_ff.status,
                        res_ff.frame_len, res_ff.byte_index, res_ff.data_byte};
endmodule

@@ hdl/binary_gps_frame_receiver.sv @@
// top level of the binary gps frame receiver
// Received bytes enter on the req_ stream, one item per byte; req_tdata holds
// the byte. The block hunts for header A0 A2, reads a 15-bit length, the
// payload, a 16-bit checksum and the B0 B3 trailer.
// Each payload byte leaves on the rsp_ stream with rsp_tuser low; at the end
// of a frame one item with rsp_tuser high carries the status (good, checksum
// mismatch, too long, bad trailer). Oversize payloads are never delivered.
// csr_wr_en writes the largest accepted payload length (255 after reset).
// Each accepted byte waits in the input register, then its result sits in
// the result register until it is taken.
// Throughput: one byte per cycle while the output is not stalled, set by
// the state update between the two registers.
// Reset empties both registers and returns the hunt to the first header byte.
// While rsp_tready is low the result holds; the input register still takes
// one more byte, then req_tready falls until the result is taken.
module binary_gps_frame_receiver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bgfr_pkg::BYTE_W-1:0]   req_tdata,   // rx_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // data_byte, byte_index, frame_len, status, recv_checksum, calc_checksum, zero
   output logic [bgfr_pkg::TDATA_W-1:0]  rsp_tdata,
   output logic                          rsp_tuser,   // frame_end
   input  logic                          csr_wr_en,
   input  logic [bgfr_pkg::LEN_W-1:0]    csr_wr_data
);
   import bgfr_pkg::*;

   logic              held_valid;
   logic [BYTE_W-1:0] held_byte;
   logic              out_free;
   logic              advance;
   logic              res_valid;
   result_type        res;

   assign advance = held_valid && out_free;

   bgfr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   bgfr_deframer u_deframer (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .rx_byte     (held_byte),
      .res_valid   (res_valid),
      .res         (res)
   );

   bgfr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && res_valid),
      .res        (res),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );
endmodule

@@ hdl/bgfr_checker.sv @@
// port-level checks for the binary gps frame receiver
`include "binary_gps_frame_receiver_defines.svh"

module bgfr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [bgfr_pkg::TDATA_W-1:0]  rsp_tdata,
   input logic                          rsp_tuser
);
   import bgfr_pkg::*;

   `BGFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   `BGFR_ASSERT_NOW(a_byte_item_clean, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_tdata[TDATA_W-1:STAT_LSB] == '0)

   `BGFR_ASSERT_NOW(a_end_item_clean, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata[FLEN_LSB-1:DATA_LSB] == '0 && rsp_tdata[PAD_LSB] == 1'b0)

   `BGFR_ASSERT_NOW(a_too_long_no_sum, clock, reset,
      rsp_tvalid && rsp_tuser && rsp_tdata[RCKS_LSB-1:STAT_LSB] == ST_TOO_LONG,
      rsp_tdata[PAD_LSB-1:CCKS_LSB] == '0)
endmodule

bind binary_gps_frame_receiver bgfr_checker u_bgfr_checker (.*);
